FILE: hdl/gpd_pkg.sv
// gpd_pkg: shared constants and types of the gaze projection deadband block
// no dependencies; imported by gpd_ctrl, gpd_dp and gaze_projection_deadband

package gpd_pkg;

  localparam int DIR_W   = 16;  // direction component width, signed Q1.15
  localparam int GAZE_W  = 16;  // projected position width, signed Q4.12
  localparam int TAN_W   = 16;  // tangent register width, unsigned Q4.12
  localparam int THR_W   = 15;  // deadband register width
  localparam int CFG_W   = 16;  // configuration write data width
  localparam int CFG_IDX_W = 2;

  localparam int Q_SHIFT = 23;               // numerator scaling
  localparam int Q_BITS  = 17;               // quotient bits produced by the divider
  localparam int CNT_W   = $clog2(Q_BITS);
  localparam int MAG_W   = DIR_W + 1;        // magnitude of a component, up to 32768
  localparam int DEN_W   = MAG_W + TAN_W;    // |z| * tan
  localparam int REM_W   = MAG_W + Q_SHIFT;  // |n| << 23
  localparam int DSH_W   = DEN_W + Q_BITS - 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TAN_H = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_V = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 2'd2;

  localparam logic [TAN_W-1:0] TAN_H_RST = 16'd4096;
  localparam logic [TAN_W-1:0] TAN_V_RST = 16'd4096;
  localparam logic [THR_W-1:0] THR_RST   = 15'd205;

  localparam logic [0:0] AXIS_H = 1'b0;
  localparam logic [0:0] AXIS_V = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;    // capture the input transaction
    logic       mul;     // form |z|*tan and the numerator of the current axis
    logic       chk;     // range check ahead of the quotient bits
    logic       step;    // one restoring division step
    logic       fin;     // saturate and store the axis result
    logic       commit;  // deadband update and output register load
    logic [0:0] axis;
  } gpd_cmd_t;

endpackage

FILE: hdl/gaze_projection_deadband.sv
// gaze_projection_deadband: top level with configuration registers and checks
// depends on gpd_pkg, gpd_ctrl and gpd_dp

// Projects a gaze direction (signed Q1.15 x, y, z) onto a normalized screen
// position in signed Q4.12: gaze_x = -(x/z)/tan_h/2, gaze_y = (y/z)/tan_v/2,
// truncated toward zero and clamped to the 16-bit range, then passes it through
// a joint two-axis deadband against the last held position. Each input transaction
// yields exactly one output transaction carrying the held position after the
// update, a changed flag and a saturated flag (z zero, tangent zero or clamp).
// Both axes share one multiplier and one restoring divider that produces one
// quotient bit per cycle; each axis runs through multiply, range check, 17
// quotient bits and finish, and the commit follows once the output register
// is free. The result waits in an output register, so a new transaction is
// accepted once the previous one has been handed to that register, from the
// cycle after that commit on. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is
// idle, as the block itself does not enforce this; writes to an index beyond
// the register list are dropped.

module gaze_projection_deadband
  import gpd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [DIR_W-1:0]     in_dir_x,
  input  logic signed [DIR_W-1:0]     in_dir_y,
  input  logic signed [DIR_W-1:0]     in_dir_z,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [GAZE_W-1:0]    out_gaze_x,
  output logic signed [GAZE_W-1:0]    out_gaze_y,
  output logic                        out_changed,
  output logic                        out_saturated
);

  // configuration registers
  logic [TAN_W-1:0] tan_h_r;
  logic [TAN_W-1:0] tan_v_r;
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tan_h_r <= TAN_H_RST;
      tan_v_r <= TAN_V_RST;
      thr_r   <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAN_H: tan_h_r <= cfg_wdata[TAN_W-1:0];
        REG_TAN_V: tan_v_r <= cfg_wdata[TAN_W-1:0];
        REG_THR:   thr_r   <= cfg_wdata[THR_W-1:0];
        default:   ;  // unmapped index, write dropped
      endcase
    end
  end

  // controller and datapath
  gpd_cmd_t cmd;
  logic     out_busy;

  gpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  gpd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .out_busy      (out_busy),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_dir_z      (in_dir_z),
    .tan_h         (tan_h_r),
    .tan_v         (tan_v_r),
    .thr           (thr_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_gaze_x    (out_gaze_x),
    .out_gaze_y    (out_gaze_y),
    .out_changed   (out_changed),
    .out_saturated (out_saturated)
  );

  // an accepted transaction keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a transaction");

  // a result is only committed when the output register is free
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result committed over a pending output transaction");

  // a commit always presents a result on the next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // the sequencer never loads and commits in the same cycle
  a_load_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit overlap");

endmodule

FILE: hdl/gpd_ctrl.sv
// gpd_ctrl: sequencer for the two projections and the deadband update
// depends on gpd_pkg; drives gpd_dp through gpd_cmd_t

module gpd_ctrl
  import gpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_busy,
  output gpd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHK,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [0:0]         axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = AXIS_H;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_BITS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (axis_r == AXIS_H) begin
          axis_nxt  = AXIS_V;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= AXIS_H;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

FILE: hdl/gpd_dp.sv
// gpd_dp: datapath with multiplier, shared restoring divider, deadband and output register
// depends on gpd_pkg; commanded by gpd_ctrl

module gpd_dp
  import gpd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  gpd_cmd_t                 cmd,
  output logic                     out_busy,
  input  logic signed [DIR_W-1:0]  in_dir_x,
  input  logic signed [DIR_W-1:0]  in_dir_y,
  input  logic signed [DIR_W-1:0]  in_dir_z,
  input  logic [TAN_W-1:0]         tan_h,
  input  logic [TAN_W-1:0]         tan_v,
  input  logic [THR_W-1:0]         thr,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [GAZE_W-1:0] out_gaze_x,
  output logic signed [GAZE_W-1:0] out_gaze_y,
  output logic                     out_changed,
  output logic                     out_saturated
);

  localparam logic signed [GAZE_W-1:0] POS_MAX = {1'b0, {(GAZE_W-1){1'b1}}};
  localparam logic signed [GAZE_W-1:0] NEG_MAX = {1'b1, {(GAZE_W-1){1'b0}}};

  logic signed [DIR_W-1:0]  x_r, y_r, z_r;
  logic [DEN_W-1:0]         den_r;
  logic [REM_W-1:0]         rem_r;
  logic [DSH_W-1:0]         dsh_r;
  logic [Q_BITS-1:0]        q_r;
  logic                     ovf_r, neg_r, npos_r, nneg_r;
  logic signed [GAZE_W-1:0] nx_r, ny_r;
  logic                     sat_r;
  logic signed [GAZE_W-1:0] held_x_r, held_y_r;
  logic                     out_valid_r, out_changed_r, out_saturated_r;
  logic signed [GAZE_W-1:0] out_gaze_x_r, out_gaze_y_r;

  // numerator and denominator of the current axis
  logic signed [DIR_W:0] n_s, z_s;
  logic [DIR_W:0]        n_mag17, z_mag17;
  logic [TAN_W-1:0]      tan_sel;
  logic                  z_neg;
  logic [DSH_W-1:0]      rem_ext;
  logic                  fit;

  always_comb begin
    if (cmd.axis == AXIS_H) begin
      n_s     = -{x_r[DIR_W-1], x_r};
      tan_sel = tan_h;
    end else begin
      n_s     = {y_r[DIR_W-1], y_r};
      tan_sel = tan_v;
    end
    z_s     = {z_r[DIR_W-1], z_r};
    z_neg   = z_r[DIR_W-1];
    n_mag17 = n_s[DIR_W] ? -n_s : n_s;
    z_mag17 = z_neg ? -z_s : z_s;
    rem_ext = DSH_W'(rem_r);
    fit     = (rem_ext >= dsh_r);
  end

  // saturation of the finished quotient
  logic                     den_zero;
  logic signed [GAZE_W-1:0] axis_val;
  logic                     axis_sat;

  always_comb begin
    den_zero = (den_r == '0);
    axis_sat = 1'b0;
    if (den_zero) begin
      axis_sat = 1'b1;
      if (npos_r)      axis_val = POS_MAX;
      else if (nneg_r) axis_val = NEG_MAX;
      else             axis_val = '0;
    end else if (neg_r) begin
      if (ovf_r || q_r > Q_BITS'(32768)) begin
        axis_sat = 1'b1;
        axis_val = NEG_MAX;
      end else begin
        axis_val = GAZE_W'(0) - q_r[GAZE_W-1:0];
      end
    end else begin
      if (ovf_r || q_r > Q_BITS'(32767)) begin
        axis_sat = 1'b1;
        axis_val = POS_MAX;
      end else begin
        axis_val = q_r[GAZE_W-1:0];
      end
    end
  end

  // deadband check against the held position
  logic signed [GAZE_W:0] dx, dy;
  logic [GAZE_W:0]        adx, ady;
  logic                   keep;

  always_comb begin
    dx   = {held_x_r[GAZE_W-1], held_x_r} - {nx_r[GAZE_W-1], nx_r};
    dy   = {held_y_r[GAZE_W-1], held_y_r} - {ny_r[GAZE_W-1], ny_r};
    adx  = dx[GAZE_W] ? -dx : dx;
    ady  = dy[GAZE_W] ? -dy : dy;
    keep = (adx <= (GAZE_W+1)'(thr)) && (ady <= (GAZE_W+1)'(thr));
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_dir_x;
      y_r   <= in_dir_y;
      z_r   <= in_dir_z;
      sat_r <= 1'b0;
    end
    if (cmd.mul) begin
      den_r  <= DEN_W'(z_mag17 * tan_sel);
      rem_r  <= {n_mag17, {Q_SHIFT{1'b0}}};
      neg_r  <= n_s[DIR_W] ^ z_neg;
      npos_r <= !n_s[DIR_W] && (n_s != '0);
      nneg_r <= n_s[DIR_W];
    end
    if (cmd.chk) begin
      ovf_r <= ({{(Q_BITS-(REM_W-DEN_W)){1'b0}}, rem_r} >= {den_r, {Q_BITS{1'b0}}});
      dsh_r <= {den_r, {(Q_BITS-1){1'b0}}};
      q_r   <= '0;
    end
    if (cmd.step) begin
      if (fit) begin
        rem_r <= REM_W'(rem_ext - dsh_r);
      end
      q_r   <= {q_r[Q_BITS-2:0], fit};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.fin) begin
      if (cmd.axis == AXIS_H) nx_r <= axis_val;
      else                    ny_r <= axis_val;
      sat_r <= sat_r | axis_sat;
    end
    if (cmd.commit) begin
      out_gaze_x_r    <= keep ? held_x_r : nx_r;
      out_gaze_y_r    <= keep ? held_y_r : ny_r;
      out_changed_r   <= !keep;
      out_saturated_r <= sat_r;
    end
  end

  // control state: held position and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r    <= '0;
      held_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        if (!keep) begin
          held_x_r <= nx_r;
          held_y_r <= ny_r;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_busy      = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_gaze_x    = out_gaze_x_r;
  assign out_gaze_y    = out_gaze_y_r;
  assign out_changed   = out_changed_r;
  assign out_saturated = out_saturated_r;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for gaze_projection_deadband
// depends on gpd_pkg and the gaze_projection_deadband rtl; drives samples and checks results

module testbench;
  import gpd_pkg::*;

  // one result transaction as the block presents it
  typedef struct packed {
    logic signed [GAZE_W-1:0] gaze_x;
    logic signed [GAZE_W-1:0] gaze_y;
    logic                     changed;
    logic                     saturated;
  } gaze_res_t;

  // kinds of rows in the directed table
  typedef enum logic [1:0] {
    ROW_SAMPLE,  // sample checked against the projection model only
    ROW_TYPED,   // sample with its result typed in by hand
    ROW_CFG      // register write, issued once the block has drained
  } row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic signed [DIR_W-1:0]  x;
    logic signed [DIR_W-1:0]  y;
    logic signed [DIR_W-1:0]  z;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         data;
    gaze_res_t                res;
  } stim_row_t;

  // index past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [GAZE_W-1:0] GAZE_MAX = 16'sh7fff;
  localparam logic signed [GAZE_W-1:0] GAZE_MIN = -16'sh8000;

  localparam int RESULT_LATENCY = 41;   // acceptance to output register
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam int IDLE_PCT       = 26;   // idle cycles per hundred on each side
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_TAN_H;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DIR_W-1:0]  in_dir_x = '0;
  logic signed [DIR_W-1:0]  in_dir_y = '0;
  logic signed [DIR_W-1:0]  in_dir_z = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [GAZE_W-1:0] out_gaze_x;
  logic signed [GAZE_W-1:0] out_gaze_y;
  logic                     out_changed;
  logic                     out_saturated;

  gaze_projection_deadband dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_dir_z      (in_dir_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_gaze_x    (out_gaze_x),
    .out_gaze_y    (out_gaze_y),
    .out_changed   (out_changed),
    .out_saturated (out_saturated)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the configuration and of the held gaze position
  logic [TAN_W-1:0]         fov_tan_h;
  logic [TAN_W-1:0]         fov_tan_v;
  logic [THR_W-1:0]         deadband;
  logic signed [GAZE_W-1:0] track_x;
  logic signed [GAZE_W-1:0] track_y;

  gaze_res_t pending_gaze[$];   // predicted results still owed by the block
  stim_row_t directed_rows[$];

  int  mismatch_count = 0;
  bit  no_idle = 1'b0;          // both sides run flat out while set
  bit  hold_request = 1'b0;     // asks the result sink for a long hold-off

  // last random sample, used to jitter around it for the deadband
  int  last_x = 0;
  int  last_y = 0;
  int  last_z = 16384;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // one axis of the perspective divide: trunc(n * 2^23 / (z * t)), clamped
  function automatic logic signed [GAZE_W-1:0] project_axis(input longint n, input longint z,
                                                            input longint t, inout bit sat);
    longint un;
    longint uz;
    longint q;
    bit     neg;
    // z or tangent zero: saturate with the sign of the numerator
    if (z == 0 || t == 0) begin
      sat = 1'b1;
      if (n > 0) return GAZE_MAX;
      if (n < 0) return GAZE_MIN;
      return '0;
    end
    neg = (n < 0) != (z < 0);
    un  = (n < 0) ? -n : n;
    uz  = (z < 0) ? -z : z;
    q   = (un << Q_SHIFT) / (uz * t);
    if (neg) begin
      // -32768 itself is reachable without clamping
      if (q > 32768) begin
        sat = 1'b1;
        return GAZE_MIN;
      end
      return GAZE_W'(-q);
    end
    if (q > 32767) begin
      sat = 1'b1;
      return GAZE_MAX;
    end
    return GAZE_W'(q);
  endfunction

  // projection plus deadband update of the held position
  function automatic gaze_res_t predict_gaze(input logic signed [DIR_W-1:0] x,
                                             input logic signed [DIR_W-1:0] y,
                                             input logic signed [DIR_W-1:0] z);
    gaze_res_t                r;
    bit                       sat;
    logic signed [GAZE_W-1:0] nx;
    logic signed [GAZE_W-1:0] ny;
    int                       dx;
    int                       dy;
    sat = 1'b0;
    nx  = project_axis(-longint'(x), longint'(z), longint'(fov_tan_h), sat);
    ny  = project_axis(longint'(y), longint'(z), longint'(fov_tan_v), sat);
    dx  = int'(track_x) - int'(nx);
    dy  = int'(track_y) - int'(ny);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    r.changed = !(dx <= int'(deadband) && dy <= int'(deadband));
    if (r.changed) begin
      track_x = nx;
      track_y = ny;
    end
    r.gaze_x    = track_x;
    r.gaze_y    = track_y;
    r.saturated = sat;
    return r;
  endfunction

  // offer one sample, idling at random first; valid stays up after acceptance
  task automatic send_sample(input logic signed [DIR_W-1:0] x, input logic signed [DIR_W-1:0] y,
                             input logic signed [DIR_W-1:0] z, input bit typed,
                             input gaze_res_t typed_res);
    gaze_res_t pred;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    do @(posedge clk); while (!in_ready);
    pred = predict_gaze(x, y, z);
    if (typed && pred !== typed_res)
      report_mismatch($sformatf("directed row (%0d,%0d,%0d) disagrees with projection model",
                                x, y, z));
    pending_gaze.push_back(typed ? typed_res : pred);
  endtask

  // register write once every owed result has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_gaze.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_TAN_H: fov_tan_h = data[TAN_W-1:0];
      REG_TAN_V: fov_tan_v = data[TAN_W-1:0];
      REG_THR:   deadband  = data[THR_W-1:0];
      default: ;  // dropped by the block
    endcase
  endtask

  function automatic void add_sample(input int x, input int y, input int z);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.x = DIR_W'(x);
    r.y = DIR_W'(y);
    r.z = DIR_W'(z);
    r.idx = REG_TAN_H;
    r.data = '0;
    r.res = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_typed(input int x, input int y, input int z,
                                    input int gx, input int gy, input bit ch, input bit sat);
    stim_row_t r;
    r.kind = ROW_TYPED;
    r.x = DIR_W'(x);
    r.y = DIR_W'(y);
    r.z = DIR_W'(z);
    r.idx = REG_TAN_H;
    r.data = '0;
    r.res.gaze_x = GAZE_W'(gx);
    r.res.gaze_y = GAZE_W'(gy);
    r.res.changed = ch;
    r.res.saturated = sat;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    r.idx = idx;
    r.data = CFG_W'(data);
    r.res = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic int pick_tan();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 65535;
      2:       return $urandom_range(1, 65535);
      default: return $urandom_range(2048, 12288);
    endcase
  endfunction

  function automatic int pick_deadband();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 32767;
      2:       return $urandom_range(0, 32767);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic int clamp_dir(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // result sink: checks every accepted result transaction and drives out_ready
  initial begin : result_sink
    int        hold_left;
    gaze_res_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_gaze.size() == 0) begin
          report_mismatch($sformatf("result (%0d,%0d) with no sample waiting",
                                    out_gaze_x, out_gaze_y));
        end else begin
          want = pending_gaze.pop_front();
          if (out_gaze_x !== want.gaze_x)
            report_mismatch($sformatf("gaze_x got %0d want %0d", out_gaze_x, want.gaze_x));
          if (out_gaze_y !== want.gaze_y)
            report_mismatch($sformatf("gaze_y got %0d want %0d", out_gaze_y, want.gaze_y));
          if (out_changed !== want.changed)
            report_mismatch($sformatf("changed got %b want %b", out_changed, want.changed));
          if (out_saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b", out_saturated,
                                      want.saturated));
        end
      end
      // long hold-off so the block fills up and stalls its input
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // stimulus: directed table, then randomized phases over several settings
  initial begin : sample_source
    int                      mode;
    int                      xi;
    int                      yi;
    int                      zi;
    int                      span;
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic signed [DIR_W-1:0] z;

    fov_tan_h = TAN_H_RST;
    fov_tan_v = TAN_V_RST;
    deadband  = THR_RST;
    track_x   = '0;
    track_y   = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: tan 1.0 on both axes, deadband 205
    add_typed(0, 0, 0, 0, 0, 1'b0, 1'b1);                    // z zero, zero numerators
    add_typed(-32768, 32767, 0, 32767, 32767, 1'b1, 1'b1);   // z zero, positive numerators
    add_typed(32767, -32768, 0, -32768, -32768, 1'b1, 1'b1); // z zero, negative numerators
    add_typed(0, 0, 32767, 0, 0, 1'b1, 1'b0);
    add_typed(-16384, 0, 16384, 2048, 0, 1'b1, 1'b0);        // half a screen to the right
    add_typed(-16384, 0, 16384, 2048, 0, 1'b0, 1'b0);        // same again, inside deadband
    add_typed(16, -16, 1, -32768, -32768, 1'b1, 1'b0);       // -32768 exactly, no clamp
    add_typed(-16, 16, 1, 32767, 32767, 1'b1, 1'b1);         // one past the top, clamped
    add_typed(32767, -32768, -1, 32767, 32767, 1'b0, 1'b1);  // negative z, clamped
    add_sample(-32768, -32768, -32768);
    add_sample(32767, 32767, 32767);
    add_sample(1, -1, -32768);
    add_sample(21845, -21846, 10922);
    add_sample(-21846, 21845, -10923);
    // zero deadband: any one-step move replaces the position
    add_cfg(REG_THR, 0);
    add_sample(-16384, 0, 16384);
    add_sample(-16383, 0, 16384);
    // widest deadband
    add_cfg(REG_THR, 32767);
    add_sample(32767, -32768, 0);
    add_sample(-32768, 32767, 0);
    add_sample(0, 0, 100);
    // tangent extremes
    add_cfg(REG_TAN_H, 1);
    add_cfg(REG_TAN_V, 65535);
    add_cfg(REG_THR, 205);
    add_sample(-1, 1, 32767);
    add_sample(-32768, 32767, 1);
    // write beyond the register list is dropped
    add_cfg(REG_UNUSED, 16'hffff);
    add_sample(-16384, 16384, 16384);
    add_sample(12345, -23456, 30000);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: write_reg(directed_rows[i].idx, directed_rows[i].data);
        default: send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                             directed_rows[i].kind == ROW_TYPED, directed_rows[i].res);
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      // each phase starts from a drained block with fresh settings
      case (phase)
        0: begin
          write_reg(REG_TAN_H, TAN_H_RST);
          write_reg(REG_TAN_V, TAN_V_RST);
          write_reg(REG_THR, CFG_W'(THR_RST));
        end
        1: begin
          write_reg(REG_TAN_H, CFG_W'(65535));
          write_reg(REG_TAN_V, CFG_W'(1));
          write_reg(REG_THR, CFG_W'(32767));
        end
        default: begin
          write_reg(REG_TAN_H, CFG_W'(pick_tan()));
          write_reg(REG_TAN_V, CFG_W'(pick_tan()));
          write_reg(REG_THR, CFG_W'(pick_deadband()));
        end
      endcase
      no_idle = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 5) hold_request = 1'b1;
        mode = $urandom_range(0, 9);
        case (mode)
          0, 1: begin
            // noise over the full range
            xi = int'($signed(16'($urandom)));
            yi = int'($signed(16'($urandom)));
            zi = int'($signed(16'($urandom)));
          end
          2: begin
            // tiny or zero z
            xi = int'($signed(16'($urandom)));
            yi = int'($signed(16'($urandom)));
            zi = int'($urandom_range(0, 8)) - 4;
          end
          3, 4, 5, 6: begin
            // realistic gaze, mostly forward, x and y within half of z
            zi = int'($urandom_range(12000, 32767));
            span = zi / 2;
            xi = int'($urandom_range(0, 2 * span)) - span;
            yi = int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 3) == 0) zi = -zi;
          end
          default: begin
            // small moves around the last sample to work the deadband edge
            xi = clamp_dir(last_x + int'($urandom_range(0, 4000)) - 2000);
            yi = clamp_dir(last_y + int'($urandom_range(0, 4000)) - 2000);
            zi = last_z;
          end
        endcase
        last_x = xi;
        last_y = yi;
        last_z = zi;
        x = DIR_W'(xi);
        y = DIR_W'(yi);
        z = DIR_W'(zi);
        send_sample(x, y, z, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_gaze.size() != 0) @(posedge clk);
    // watch for stray results after the last one
    repeat (2 * RESULT_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_gaze.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : run_limit
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_gaze.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
hdl/gpd_pkg.sv
hdl/gpd_ctrl.sv
hdl/gpd_dp.sv
hdl/gaze_projection_deadband.sv
bench/testbench.sv
